// File: sv/nfsa_pkg.sv
// Shared types and constants for the next-fit slot allocator.
// No dependencies; imported by nfsa_ctrl, nfsa_dp and the top level.
package nfsa_pkg;

  localparam int OP_W     = 1;
  localparam int SLOT_W   = 5;
  localparam int FREE_W   = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 3;

  // Largest pool; the slot and count port widths are sized for it
  localparam int MAX_SLOTS = 32;

  // Register reset value of pool_size_log2
  localparam int CFG_RESET = 5;

  localparam logic [OP_W-1:0] OP_ATTACH = 1'b0;
  localparam logic [OP_W-1:0] OP_DETACH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_NOT_IN_USE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic    load;
    logic    scan_step;
    logic    commit_grant;
    logic    commit_release;
    logic    write_result;
    status_t result;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_detach;
    logic free_zero;
    logic cur_busy;
    logic scan_last;
    logic release_ok;
  } dp_stat_t;

endpackage

// File: sv/nfsa_ctrl.sv
// Control state machine of the slot allocator: input/output handshake and
// sequencing of the slot scan. Depends on nfsa_pkg.
module nfsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  nfsa_pkg::dp_stat_t  stat,
  output nfsa_pkg::ctrl_cmd_t cmd
);
  import nfsa_pkg::*;

  state_t state, state_next;
  logic   out_free;

  // Result register can take a new value this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.write_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next         = state;
    cmd                = '0;
    cmd.result         = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_detach) begin
          if (out_free) begin
            cmd.write_result   = 1'b1;
            cmd.commit_release = stat.release_ok;
            cmd.result         = stat.release_ok ? ST_OK : ST_NOT_IN_USE;
            state_next         = S_IDLE;
          end
        end else if (stat.free_zero) begin
          if (out_free) begin
            cmd.write_result = 1'b1;
            cmd.result       = ST_NO_FREE;
            state_next       = S_IDLE;
          end
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.cur_busy) begin
          if (out_free) begin
            cmd.write_result = 1'b1;
            cmd.commit_grant = 1'b1;
            cmd.result       = ST_OK;
            state_next       = S_IDLE;
          end
        end else if (stat.scan_last) begin
          // whole pool busy even though the count said otherwise
          if (out_free) begin
            cmd.write_result = 1'b1;
            cmd.result       = ST_NO_FREE;
            state_next       = S_IDLE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.write_result |-> (!out_valid || out_ready))
    else $error("result register overwritten before transfer");

  a_one_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit_grant && cmd.commit_release))
    else $error("grant and release committed together");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.write_result |=> out_valid)
    else $error("written result not presented");

endmodule

// File: sv/nfsa_dp.sv
// Datapath of the slot allocator: busy bits, free count, search position,
// pool size register, scan counter and result register. Depends on nfsa_pkg.
module nfsa_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [nfsa_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [nfsa_pkg::OP_W-1:0]           op,
  input  logic [nfsa_pkg::SLOT_W-1:0]         release_slot,
  input  nfsa_pkg::ctrl_cmd_t                 cmd,
  output nfsa_pkg::dp_stat_t                  stat,
  output logic [nfsa_pkg::STATUS_W-1:0]       status,
  output logic [nfsa_pkg::SLOT_W-1:0]         granted_slot,
  output logic [nfsa_pkg::FREE_W-1:0]         free_count
);
  import nfsa_pkg::*;

  localparam int IDX_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LOG2_MAX   = $clog2(MAX_SLOTS + 1) - 1;
  localparam int LOG2_W     = (LOG2_MAX > 0) ? $clog2(LOG2_MAX + 1) : 1;
  localparam int RESET_LOG2 = (CFG_RESET > LOG2_MAX) ? LOG2_MAX : CFG_RESET;
  localparam int CMP_W      = IDX_W + SLOT_W + 1;

  logic [MAX_SLOTS-1:0]  busy;
  logic [LOG2_W-1:0]     pool_log2;
  logic [FREE_W-1:0]     slots_free;
  logic [IDX_W-1:0]      search_start;
  logic [OP_W-1:0]       op_q;
  logic [SLOT_W-1:0]     rel_q;
  logic [IDX_W-1:0]      scan_cnt;

  logic [IDX_W:0]        size;
  logic [IDX_W-1:0]      mask;
  logic [IDX_W-1:0]      scan_idx;
  logic [IDX_W-1:0]      rel_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rel_in_pool;
  logic [LOG2_W-1:0]     cfg_log2;
  logic [FREE_W-1:0]     free_after;

  function automatic logic [FREE_W-1:0] pool_free(input logic [LOG2_W-1:0] l);
    logic [31:0] n;
    n = 32'd1 << l;
    return FREE_W'(n);
  endfunction

  // Register values above the largest pool saturate
  assign cfg_log2 = (int'(cfg_wdata) > LOG2_MAX) ? LOG2_W'(LOG2_MAX) : LOG2_W'(cfg_wdata);

  assign size        = (IDX_W + 1)'(1) << pool_log2;
  assign mask        = IDX_W'(size - (IDX_W + 1)'(1));
  assign scan_idx    = (search_start + scan_cnt) & mask;
  assign rel_idx     = IDX_W'(rel_q);
  assign rel_in_pool = CMP_W'(rel_q) < CMP_W'(size);
  assign rd_idx      = (op_q == OP_DETACH) ? rel_idx : scan_idx;

  assign stat.is_detach  = (op_q == OP_DETACH);
  assign stat.free_zero  = (slots_free == '0);
  assign stat.cur_busy   = busy[rd_idx];
  assign stat.scan_last  = (scan_cnt == mask);
  assign stat.release_ok = rel_in_pool && busy[rd_idx];

  always_comb begin
    free_after = slots_free;
    if (cmd.commit_grant) begin
      free_after = slots_free - FREE_W'(1);
    end else if (cmd.commit_release) begin
      free_after = slots_free + FREE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= '0;
      pool_log2    <= LOG2_W'(RESET_LOG2);
      slots_free   <= pool_free(LOG2_W'(RESET_LOG2));
      search_start <= '0;
    end else if (cfg_we) begin
      // a new pool size restarts the allocator
      busy         <= '0;
      pool_log2    <= cfg_log2;
      slots_free   <= pool_free(cfg_log2);
      search_start <= '0;
    end else begin
      slots_free <= free_after;
      if (cmd.commit_grant) begin
        busy[scan_idx] <= 1'b1;
        search_start   <= scan_idx + IDX_W'(1);
      end else if (cmd.commit_release) begin
        busy[rel_idx] <= 1'b0;
        search_start  <= rel_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= op;
      rel_q    <= release_slot;
      scan_cnt <= '0;
    end else if (cmd.scan_step) begin
      scan_cnt <= scan_cnt + IDX_W'(1);
    end
    if (cmd.write_result) begin
      status       <= cmd.result;
      granted_slot <= cmd.commit_grant ? SLOT_W'(scan_idx) : '0;
      free_count   <= free_after;
    end
  end

  a_grant_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_grant |-> !busy[scan_idx])
    else $error("grant of a busy slot");

  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(slots_free) <= CMP_W'(size))
    else $error("free count exceeds pool size");

endmodule

// File: sv/next_fit_slot_allocator_unit.sv
// Next-fit slot allocator. Detach, and attach on an empty count: result
// registered in the execute state that follows transfer in. Attach: the
// one-slot-per-cycle scan then skips busy slots, at most the whole pool.
// Next item is taken the cycle after the result is registered; a stalled
// output holds completion. Reset: all slots free, pool_size_log2 = 5,
// search position 0. Depends on nfsa_pkg, nfsa_ctrl, nfsa_dp.
module next_fit_slot_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [nfsa_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nfsa_pkg::OP_W-1:0]     op,
  input  logic [nfsa_pkg::SLOT_W-1:0]   release_slot,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nfsa_pkg::STATUS_W-1:0] status,
  output logic [nfsa_pkg::SLOT_W-1:0]   granted_slot,
  output logic [nfsa_pkg::FREE_W-1:0]   free_count
);
  import nfsa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  nfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nfsa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .op           (op),
    .release_slot (release_slot),
    .cmd          (cmd),
    .stat         (stat),
    .status       (status),
    .granted_slot (granted_slot),
    .free_count   (free_count)
  );

endmodule
